[hw/rtl/auto_exposure_step_defines.svh]
// Assertion macros for the auto exposure step block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef AUTO_EXPOSURE_STEP_DEFINES_SVH
`define AUTO_EXPOSURE_STEP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define AES_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("auto_exposure_step: same-cycle check failed");

// Next-cycle implication
`define AES_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("auto_exposure_step: next-cycle check failed");

`else

`define AES_ASSERT_IMP(name, ante, cons)
`define AES_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[hw/rtl/aes_pkg.sv]
`default_nettype none

package aes_pkg;

	// Fixed field widths
	localparam int LUMA_BITS   = 8;
	localparam int RATE_BITS   = 7;
	localparam int FACTOR_BITS = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int DIV_PRESHIFT   = 6;

	// Arithmetic constants
	localparam logic [7:0] MID_LEVEL = 8'd128;
	localparam logic [7:0] PCT_FULL  = 8'd100;

	// Reciprocal of 100 scaled by 2^19, rounded up; exact for partial dividends below 25600
	localparam logic [27:0] DIV100_RECIP = 28'd5243;
	localparam int          DIV100_SHIFT = 19;

	// Register reset values
	localparam logic [7:0]  TARGET_RESET    = 8'd128;
	localparam logic [7:0]  DEAD_BAND_RESET = 8'd5;
	localparam logic [6:0]  MAX_RATE_RESET  = 7'd30;
	localparam logic [6:0]  MIN_RATE_RESET  = 7'd2;
	localparam logic [31:0] CEILING_RESET   = 32'h00FF_FFFF;

	// Register indexes on the configuration channel
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TARGET    = 3'd0,
		REG_CEILING   = 3'd1,
		REG_DEAD_BAND = 3'd2,
		REG_MAX_RATE  = 3'd3,
		REG_MIN_RATE  = 3'd4,
		REG_START     = 3'd5
	} cfg_reg_t;

	// Adjustment direction codes
	typedef enum logic [1:0] {
		DIR_HELD = 2'd0,
		DIR_DOWN = 2'd1,
		DIR_UP   = 2'd2
	} dir_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATE,
		ST_CLAMP,
		ST_SCALE,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_FINISH
	} state_t;

	// Fixed-width configuration fields
	typedef struct packed {
		logic [7:0] target;
		logic [7:0] dead_band;
		logic [6:0] max_rate;
		logic [6:0] min_rate;
	} cfg_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

[hw/rtl/aes_cfg_regs.sv]
`default_nettype none

module aes_cfg_regs #(
	parameter int EXPOSURE_BITS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [aes_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [EXPOSURE_BITS-1:0]            cfg_data,
	output aes_pkg::cfg_t                            cfg,
	output logic [EXPOSURE_BITS-1:0]                 ceiling,
	output logic                                     start_load,
	output logic [EXPOSURE_BITS-1:0]                 start_value
);

	localparam logic [EXPOSURE_BITS-1:0] CeilReset = EXPOSURE_BITS'(aes_pkg::CEILING_RESET);

	aes_pkg::cfg_t            cfg_q;
	logic [EXPOSURE_BITS-1:0] ceiling_q;
	logic                     wr_en;

	assign cfg_ready   = 1'b1;
	assign wr_en       = cfg_valid & cfg_ready;
	assign cfg         = cfg_q;
	assign ceiling     = ceiling_q;
	assign start_value = cfg_data;

	// Flag a start exposure write so the held value reloads
	always_comb begin
		start_load = 1'b0;
		if (wr_en && (cfg_index == aes_pkg::REG_START)) begin
			start_load = 1'b1;
		end
	end

	// Store register writes, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target    <= aes_pkg::TARGET_RESET;
			cfg_q.dead_band <= aes_pkg::DEAD_BAND_RESET;
			cfg_q.max_rate  <= aes_pkg::MAX_RATE_RESET;
			cfg_q.min_rate  <= aes_pkg::MIN_RATE_RESET;
			ceiling_q       <= CeilReset;
		end else if (wr_en) begin
			case (cfg_index)
				aes_pkg::REG_TARGET:    cfg_q.target    <= cfg_data[7:0];
				aes_pkg::REG_CEILING:   ceiling_q       <= cfg_data;
				aes_pkg::REG_DEAD_BAND: cfg_q.dead_band <= cfg_data[7:0];
				aes_pkg::REG_MAX_RATE:  cfg_q.max_rate  <= cfg_data[6:0];
				aes_pkg::REG_MIN_RATE:  cfg_q.min_rate  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/aes_div100.sv]
`default_nettype none

// Divide by 100 one dividend byte per cycle, each step by reciprocal multiplication
module aes_div100 #(
	parameter int DVD_BITS = 32
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      start,
	input  wire logic [DVD_BITS-1:0]                       dividend,
	output aes_pkg::div_status_t                           status,
	output logic [DVD_BITS-aes_pkg::DIV_PRESHIFT-1:0]      quotient
);

	localparam int QuoBits  = DVD_BITS - aes_pkg::DIV_PRESHIFT;
	localparam int Steps    = (DVD_BITS + 7) / 8;
	localparam int PadBits  = Steps * 8;
	localparam int CntBits  = $clog2(Steps + 1);

	logic [6:0]          rem_q;
	logic [PadBits-1:0]  dvd_q;
	logic [PadBits-1:0]  quo_q;
	logic [CntBits-1:0]  cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [14:0]         part;
	logic [27:0]         recip_prod;
	logic [7:0]          qbyte;
	logic [14:0]         back;
	logic [14:0]         rem_wide;
	logic [6:0]          rem_nxt;

	// Remainder and next byte form a partial dividend below 25600
	always_comb begin
		part       = {rem_q, dvd_q[PadBits-1 -: 8]};
		recip_prod = 28'(part) * aes_pkg::DIV100_RECIP;
		qbyte      = recip_prod[aes_pkg::DIV100_SHIFT +: 8];
		back       = 15'(qbyte) * 15'(aes_pkg::PCT_FULL);
		rem_wide   = part - back;
		rem_nxt    = rem_wide[6:0];
	end

	// Shift in one quotient byte per step, most significant first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= PadBits'(dividend);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[PadBits-9:0], 8'd0};
			quo_q <= {quo_q[PadBits-9:0], qbyte};
		end
	end

	// Count steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CntBits'(Steps);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntBits'(1);
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q[QuoBits-1:0];

endmodule

`default_nettype wire

[hw/rtl/auto_exposure_step.sv]
// Proportional auto exposure step.
// Input stream (s_axis): one request per video frame carrying the frame's mean
// luma. Output stream (m_axis): one result per request with the new exposure,
// the direction of the change and the percentage rate applied.
// Configuration channel (cfg_*): target, ceiling, dead band, rate limits and a
// start exposure; writing the start exposure loads the held exposure. Write it
// only while no request is in flight.
// A request that needs an adjustment passes through RATE, CLAMP, SCALE,
// DIV_LOAD, DIV_RUN and FINISH before its result enters the output register:
// one shared multiplier forms the rate span and then the scaled exposure, and
// the divide by 100 retires one byte of the product per cycle.
// A request inside the dead band goes from acceptance straight to FINISH and
// enters the output register once that register is free. s_axis_tready is high
// only while the sequencer is idle, which it is again as each result is
// registered, so a new request is accepted only after the last one finishes.
// The finished result sits in an output register; if the receiver stalls, the
// block may accept the next request and hold it at its last step until the
// register frees. The held exposure updates when a result enters the register.
// Reset restores the configuration registers to their defaults, the held
// exposure to 1, and empties the output register.
`default_nettype none

`include "auto_exposure_step_defines.svh"

module auto_exposure_step #(
	parameter int EXPOSURE_BITS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [7:0] mean_luma
	input  wire logic [7:0]                          s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [EXPOSURE_BITS-1:0] exposure_value, then adjust_dir (2), applied_rate (7)
	output logic [((EXPOSURE_BITS+9+7)/8)*8-1:0]     m_axis_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [aes_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [EXPOSURE_BITS-1:0]            cfg_data
);

	localparam int ProdBits = EXPOSURE_BITS + 8;
	localparam int QuoBits  = ProdBits - aes_pkg::DIV_PRESHIFT;
	localparam int OutBits  = ((EXPOSURE_BITS + 9 + 7) / 8) * 8;

	aes_pkg::state_t          state_q;
	aes_pkg::state_t          state_nxt;
	aes_pkg::cfg_t            cfg;
	aes_pkg::div_status_t     div_status;
	logic [EXPOSURE_BITS-1:0] ceiling;
	logic                     start_load;
	logic [EXPOSURE_BITS-1:0] start_value;

	logic [EXPOSURE_BITS-1:0] held_q;
	logic [7:0]               abs_err_q;
	logic                     over_q;
	logic                     adjust_q;
	logic [6:0]               rate_q;
	logic [7:0]               factor_q;
	logic [ProdBits-1:0]      mul_q;
	logic [QuoBits-1:0]       quotient;

	logic                     out_valid_q;
	logic [EXPOSURE_BITS-1:0] out_exp_q;
	logic [1:0]               out_dir_q;
	logic [6:0]               out_rate_q;

	logic                     in_fire;
	logic                     out_free;
	logic                     mul_en;
	logic                     div_start;
	logic                     finish_fire;

	logic [7:0]               target;
	logic                     over_in;
	logic [7:0]               abs_err_in;
	logic                     adjust_in;
	logic                     span_neg;
	logic [6:0]               span_mag;
	logic [EXPOSURE_BITS-1:0] mul_a;
	logic [7:0]               mul_b;
	logic signed [9:0]        rate_raw;
	logic signed [9:0]        rate_hi;
	logic signed [9:0]        rate_lo;
	logic [6:0]               rate_c;
	logic [7:0]               factor_c;
	logic [QuoBits-1:0]       val;
	logic [QuoBits-1:0]       ceil_eff;
	logic [EXPOSURE_BITS-1:0] result;

	aes_cfg_regs #(
		.EXPOSURE_BITS(EXPOSURE_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.ceiling    (ceiling),
		.start_load (start_load),
		.start_value(start_value)
	);

	aes_div100 #(
		.DVD_BITS(ProdBits)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mul_q),
		.status  (div_status),
		.quotient(quotient)
	);

	// Error against the target, zero target meaning mid level
	always_comb begin
		target     = (cfg.target == '0) ? aes_pkg::MID_LEVEL : cfg.target;
		over_in    = (s_axis_tdata > target);
		abs_err_in = over_in ? (s_axis_tdata - target) : (target - s_axis_tdata);
		adjust_in  = (abs_err_in > cfg.dead_band);
	end

	// Rate span between the limits, may be negative
	always_comb begin
		span_neg = (cfg.min_rate > cfg.max_rate);
		span_mag = span_neg ? (cfg.min_rate - cfg.max_rate) : (cfg.max_rate - cfg.min_rate);
	end

	// Shared multiplier operand select
	always_comb begin
		if (state_q == aes_pkg::ST_SCALE) begin
			mul_a = held_q;
			mul_b = factor_q;
		end else begin
			mul_a = EXPOSURE_BITS'(span_mag);
			mul_b = abs_err_q;
		end
	end

	// Rate from the registered span product, then clamp to max and then min
	always_comb begin
		rate_raw = span_neg
			? ($signed({3'b000, cfg.min_rate}) - $signed({2'b00, mul_q[14:7]}))
			: ($signed({3'b000, cfg.min_rate}) + $signed({2'b00, mul_q[14:7]}));
		rate_hi  = (rate_raw > $signed({3'b000, cfg.max_rate}))
			? $signed({3'b000, cfg.max_rate}) : rate_raw;
		rate_lo  = (rate_hi < $signed({3'b000, cfg.min_rate}))
			? $signed({3'b000, cfg.min_rate}) : rate_hi;
		rate_c   = rate_lo[6:0];
		if (over_q) begin
			factor_c = (rate_c >= aes_pkg::PCT_FULL[6:0])
				? 8'd0 : (aes_pkg::PCT_FULL - {1'b0, rate_c});
		end else begin
			factor_c = aes_pkg::PCT_FULL + {1'b0, rate_c};
		end
	end

	// Final clamp into 1..ceiling
	always_comb begin
		val      = adjust_q ? quotient : QuoBits'(held_q);
		ceil_eff = (ceiling == '0) ? QuoBits'(1) : QuoBits'(ceiling);
		if (val == '0) begin
			val = QuoBits'(1);
		end
		if (val > ceil_eff) begin
			val = ceil_eff;
		end
		result = val[EXPOSURE_BITS-1:0];
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			aes_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_nxt = adjust_in ? aes_pkg::ST_RATE : aes_pkg::ST_FINISH;
				end
			end
			aes_pkg::ST_RATE:     state_nxt = aes_pkg::ST_CLAMP;
			aes_pkg::ST_CLAMP:    state_nxt = aes_pkg::ST_SCALE;
			aes_pkg::ST_SCALE:    state_nxt = aes_pkg::ST_DIV_LOAD;
			aes_pkg::ST_DIV_LOAD: state_nxt = aes_pkg::ST_DIV_RUN;
			aes_pkg::ST_DIV_RUN: begin
				if (div_status.done) begin
					state_nxt = aes_pkg::ST_FINISH;
				end
			end
			aes_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nxt = aes_pkg::ST_IDLE;
				end
			end
			default: state_nxt = aes_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_axis_tready = (state_q == aes_pkg::ST_IDLE);
		mul_en        = (state_q == aes_pkg::ST_RATE) || (state_q == aes_pkg::ST_SCALE);
		div_start     = (state_q == aes_pkg::ST_DIV_LOAD);
		out_free      = !out_valid_q || m_axis_tready;
		finish_fire   = (state_q == aes_pkg::ST_FINISH) && out_free;
		in_fire       = s_axis_tvalid && s_axis_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Capture the request and the working values
	always_ff @(posedge clk) begin
		if (in_fire) begin
			abs_err_q <= abs_err_in;
			over_q    <= over_in;
			adjust_q  <= adjust_in;
		end
		if (mul_en) begin
			mul_q <= {8'd0, mul_a} * {{EXPOSURE_BITS{1'b0}}, mul_b};
		end
		if (state_q == aes_pkg::ST_CLAMP) begin
			rate_q   <= rate_c;
			factor_q <= factor_c;
		end
	end

	// Held exposure: reload on a start write, advance on each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= EXPOSURE_BITS'(1);
		end else if (start_load) begin
			held_q <= start_value;
		end else if (finish_fire) begin
			held_q <= result;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_fire) begin
			out_exp_q <= result;
			if (adjust_q) begin
				out_dir_q  <= over_q ? aes_pkg::DIR_DOWN : aes_pkg::DIR_UP;
				out_rate_q <= rate_q;
			end else begin
				out_dir_q  <= aes_pkg::DIR_HELD;
				out_rate_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OutBits'({out_rate_q, out_dir_q, out_exp_q});

	`AES_ASSERT_IMP(a_exp_nonzero, m_axis_tvalid, out_exp_q != '0)
	`AES_ASSERT_IMP(a_held_no_rate, m_axis_tvalid && (out_dir_q == aes_pkg::DIR_HELD), out_rate_q == '0)
	`AES_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready)
	`AES_ASSERT_IMP(a_div_in_run, div_status.busy, state_q == aes_pkg::ST_DIV_RUN)

endmodule

`default_nettype wire
